// ===== design/tsss_pkg.sv =====
// ----------------------------------------------------------------------------
// tsss_pkg
// Shared constants and types for the two-segment similarity score block.
// ----------------------------------------------------------------------------
package tsss_pkg;

    // Longest feature vector that the block handles.
    localparam int MAX_DIM = 1024;

    // Field and register widths.
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int SUM_W   = 41;
    localparam int SCORE_W = 18;
    localparam int LEN_W   = 11;
    localparam int CNT_W   = $clog2(MAX_DIM + 1);
    localparam int CMP_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int IDX_W   = 2;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_SEG1_LEN  = 2'd0;
    localparam logic [IDX_W-1:0] REG_TOTAL_LEN = 2'd1;

    // Register reset values.
    localparam logic [LEN_W-1:0] SEG1_LEN_RST  = 11'd512;
    localparam logic [LEN_W-1:0] TOTAL_LEN_RST = 11'd1024;

    // Accumulator saturation limits, Q.30.
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Score math: 0.535 in Q.32 plus half an LSB of Q.16 for rounding.
    localparam int SCORE_SUM_W = SUM_W + 2;
    localparam logic signed [SCORE_SUM_W-1:0] SCORE_BIAS = 43'sd2297840271;
    localparam int SCORE_Q_W = SCORE_SUM_W - 16;
    localparam logic signed [SCORE_Q_W-1:0] SCORE_HI = 27'sd65536;
    localparam logic signed [SCORE_Q_W-1:0] SCORE_LO = -27'sd131072;

    // One product on its way to the accumulators.
    typedef struct packed {
        logic                     v;
        logic                     first;
        logic                     last;
        logic signed [PROD_W-1:0] p;
    } t_prod;

    // Final sums of one vector on their way to the score stage.
    typedef struct packed {
        logic                    v;
        logic signed [SUM_W-1:0] s1;
        logic signed [SUM_W-1:0] s2;
    } t_fin;

endpackage

// ===== design/tsss_if.sv =====
// ----------------------------------------------------------------------------
// tsss interfaces
// Valid/ready channels for element pairs, scores and register writes.
// ----------------------------------------------------------------------------
interface tsss_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [tsss_pkg::ELEM_W-1:0]       elem_a;
    logic signed [tsss_pkg::ELEM_W-1:0]       elem_b;
    modport source (output valid, output elem_a, output elem_b, input ready);
    modport sink   (input valid, input elem_a, input elem_b, output ready);
endinterface

interface tsss_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [tsss_pkg::SCORE_W-1:0]      score;
    modport source (output valid, output score, input ready);
    modport sink   (input valid, input score, output ready);
endinterface

interface tsss_cfg_if;
    logic                                     valid;
    logic                                     ready;
    logic [tsss_pkg::IDX_W-1:0]               index;
    logic [tsss_pkg::LEN_W-1:0]               data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/two_segment_similarity_score_top.sv =====
// ----------------------------------------------------------------------------
// two_segment_similarity_score_top
// Dot-product similarity score over two segments of a feature vector.
// ----------------------------------------------------------------------------
// The block takes one pair of Q1.15 elements per cycle unless stalled. A
// registered multiplier feeds one saturating 41-bit accumulator stage, so
// the rate is one item per clock when not stalled. After a vector's last
// pair is accepted, it moves through the product and final-sum registers, and
// its score is held in the output register. The input side stalls only when a
// finished score waits undrained in the output register and the next vector's
// final sums wait behind it. The user must write registers through the
// configuration port only while no item is in flight, unenforced by the block.
module two_segment_similarity_score_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsss_in_if.sink     i_in,
    tsss_cfg_if.sink    i_cfg,
    tsss_out_if.source  o_out
);

    tsss_pkg::t_prod prod;
    tsss_pkg::t_fin  fin;
    logic            fin_taken;
    logic            en;

    // Everything ahead of the final-sum register advances unless it is blocked.
    assign en = !(fin.v && !fin_taken);

    tsss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_prod  (prod)
    );

    tsss_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_prod      (prod),
        .i_fin_taken (fin_taken),
        .o_fin       (fin)
    );

    tsss_score u_score (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin       (fin),
        .o_fin_taken (fin_taken),
        .o_out       (o_out)
    );

endmodule

// ===== design/tsss_front.sv =====
// ----------------------------------------------------------------------------
// tsss_front
// Configuration registers, pair counter and the registered multiplier.
// ----------------------------------------------------------------------------
module tsss_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    tsss_in_if.sink              i_in,
    tsss_cfg_if.sink             i_cfg,
    output tsss_pkg::t_prod      o_prod
);

    logic [tsss_pkg::LEN_W-1:0] r_seg1_len;
    logic [tsss_pkg::LEN_W-1:0] r_total_len;
    logic [tsss_pkg::CNT_W-1:0] r_idx;
    logic [tsss_pkg::CNT_W-1:0] n_idx;
    tsss_pkg::t_prod            r_prod;
    tsss_pkg::t_prod            n_prod;
    logic [tsss_pkg::CMP_W-1:0] tot_eff;
    logic [tsss_pkg::CMP_W-1:0] seg_eff;
    logic [tsss_pkg::CMP_W-1:0] idx_ext;
    logic [tsss_pkg::CMP_W-1:0] idx_inc;
    logic                       accept;
    logic                       last;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_en;
    assign accept      = i_in.valid && i_en;

    // Effective lengths: zero total acts as one, and both clamp to the vector size.
    always_comb begin
        if (r_total_len == '0) begin
            tot_eff = tsss_pkg::CMP_W'(1);
        end else if (tsss_pkg::CMP_W'(r_total_len) > tsss_pkg::CMP_W'(tsss_pkg::MAX_DIM)) begin
            tot_eff = tsss_pkg::CMP_W'(tsss_pkg::MAX_DIM);
        end else begin
            tot_eff = tsss_pkg::CMP_W'(r_total_len);
        end
        seg_eff = (tsss_pkg::CMP_W'(r_seg1_len) > tot_eff) ? tot_eff
                                                           : tsss_pkg::CMP_W'(r_seg1_len);
    end

    // Segment and end-of-vector decision for the pair being accepted.
    assign idx_ext = tsss_pkg::CMP_W'(r_idx);
    assign idx_inc = idx_ext + tsss_pkg::CMP_W'(1);
    assign last    = idx_inc >= tot_eff;

    always_comb begin
        n_idx = r_idx;
        if (accept) begin
            n_idx = last ? '0 : idx_inc[tsss_pkg::CNT_W-1:0];
        end
        n_prod = r_prod;
        if (i_en) begin
            n_prod.v     = i_in.valid;
            n_prod.first = idx_ext < seg_eff;
            n_prod.last  = last;
            n_prod.p     = i_in.elem_a * i_in.elem_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg1_len  <= tsss_pkg::SEG1_LEN_RST;
            r_total_len <= tsss_pkg::TOTAL_LEN_RST;
            r_idx       <= '0;
            r_prod.v    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    tsss_pkg::REG_SEG1_LEN:  r_seg1_len  <= i_cfg.data;
                    tsss_pkg::REG_TOTAL_LEN: r_total_len <= i_cfg.data;
                    default: ;
                endcase
            end
            r_idx    <= n_idx;
            r_prod.v <= n_prod.v;
        end
        r_prod.first <= n_prod.first;
        r_prod.last  <= n_prod.last;
        r_prod.p     <= n_prod.p;
    end

    assign o_prod = r_prod;

endmodule

// ===== design/tsss_accum.sv =====
// ----------------------------------------------------------------------------
// tsss_accum
// Saturating accumulators for both segments and the final-sum register.
// ----------------------------------------------------------------------------
module tsss_accum (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  tsss_pkg::t_prod      i_prod,
    input  logic                 i_fin_taken,
    output tsss_pkg::t_fin       o_fin
);

    logic signed [tsss_pkg::SUM_W-1:0] r_sum1;
    logic signed [tsss_pkg::SUM_W-1:0] r_sum2;
    logic signed [tsss_pkg::SUM_W-1:0] add_in;
    logic signed [tsss_pkg::SUM_W:0]   add_raw;
    logic signed [tsss_pkg::SUM_W-1:0] add_sat;
    logic signed [tsss_pkg::SUM_W-1:0] new1;
    logic signed [tsss_pkg::SUM_W-1:0] new2;
    tsss_pkg::t_fin                    r_fin;
    logic                              step;

    assign step = i_en && i_prod.v;

    // One shared saturating adder; the segment flag picks the accumulator.
    assign add_in  = i_prod.first ? r_sum1 : r_sum2;
    assign add_raw = (tsss_pkg::SUM_W+1)'(add_in) + (tsss_pkg::SUM_W+1)'(i_prod.p);
    always_comb begin
        if (add_raw > (tsss_pkg::SUM_W+1)'(tsss_pkg::SUM_MAX)) begin
            add_sat = tsss_pkg::SUM_MAX;
        end else if (add_raw < (tsss_pkg::SUM_W+1)'(tsss_pkg::SUM_MIN)) begin
            add_sat = tsss_pkg::SUM_MIN;
        end else begin
            add_sat = add_raw[tsss_pkg::SUM_W-1:0];
        end
        new1 = i_prod.first ? add_sat : r_sum1;
        new2 = i_prod.first ? r_sum2 : add_sat;
    end

    // The last pair hands the sums on and clears the accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum1  <= '0;
            r_sum2  <= '0;
            r_fin.v <= 1'b0;
        end else begin
            if (step) begin
                r_sum1 <= i_prod.last ? '0 : new1;
                r_sum2 <= i_prod.last ? '0 : new2;
            end
            if (step && i_prod.last) begin
                r_fin.v <= 1'b1;
            end else if (i_fin_taken) begin
                r_fin.v <= 1'b0;
            end
        end
        if (step && i_prod.last) begin
            r_fin.s1 <= new1;
            r_fin.s2 <= new2;
        end
    end

    assign o_fin = r_fin;

endmodule

// ===== design/tsss_score.sv =====
// ----------------------------------------------------------------------------
// tsss_score
// Forms the Q.16 score from the final sums and holds it in the output register.
// ----------------------------------------------------------------------------
module tsss_score (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tsss_pkg::t_fin       i_fin,
    output logic                 o_fin_taken,
    tsss_out_if.source           o_out
);

    logic signed [tsss_pkg::SCORE_SUM_W-1:0] q32;
    logic signed [tsss_pkg::SCORE_Q_W-1:0]   q16;
    logic signed [tsss_pkg::SCORE_W-1:0]     clamped;
    logic signed [tsss_pkg::SCORE_W-1:0]     r_score;
    logic                                    r_valid;

    // Sum of both segments plus the bias, rounded to Q.16 by an arithmetic shift.
    assign q32 = tsss_pkg::SCORE_SUM_W'(i_fin.s1) + tsss_pkg::SCORE_SUM_W'(i_fin.s2)
               + tsss_pkg::SCORE_BIAS;
    assign q16 = q32[tsss_pkg::SCORE_SUM_W-1:16];

    always_comb begin
        if (q16 > tsss_pkg::SCORE_HI) begin
            clamped = tsss_pkg::SCORE_HI[tsss_pkg::SCORE_W-1:0];
        end else if (q16 < tsss_pkg::SCORE_LO) begin
            clamped = tsss_pkg::SCORE_LO[tsss_pkg::SCORE_W-1:0];
        end else begin
            clamped = q16[tsss_pkg::SCORE_W-1:0];
        end
    end

    // The output register takes a new score when it is empty or being drained.
    assign o_fin_taken = i_fin.v && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_fin_taken) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
        if (o_fin_taken) begin
            r_score <= clamped;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.score = r_score;

endmodule
